[src/hmed_pkg.sv]
`default_nettype none

package hmed_pkg;

    // Width of the length value and of the body counter
    localparam int LENGTH_WIDTH = 32;
    // Width of the length and count fields on the result channel
    localparam int FIELD_WIDTH  = 32;
    // Characters in "Content-Length:"
    localparam int NAME_LEN     = 15;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_VT    = 8'h0B;
    localparam logic [7:0] CHAR_FF    = 8'h0C;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // Progress through the number after the field name
    typedef enum logic [1:0] {
        NP_NO_NAME = 2'd0,   // name not matched yet
        NP_LEAD    = 2'd1,   // skipping blanks, sign allowed
        NP_DIGITS  = 2'd2,   // sign or digits taken
        NP_ENDED   = 2'd3    // number finished
    } num_phase_t;

    // One result beat
    typedef struct packed {
        logic [FIELD_WIDTH-1:0] body_bytes;
        logic [FIELD_WIDTH-1:0] expected_length;
        logic                   length_found;
        logic                   header_complete;
        logic                   message_complete;
    } result_t;

    // Character of "Content-Length:" at a given position
    function automatic logic [7:0] name_char(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = 8'h43; // C
            4'd1:    ch = 8'h6F; // o
            4'd2:    ch = 8'h6E; // n
            4'd3:    ch = 8'h74; // t
            4'd4:    ch = 8'h65; // e
            4'd5:    ch = 8'h6E; // n
            4'd6:    ch = 8'h74; // t
            4'd7:    ch = 8'h2D; // -
            4'd8:    ch = 8'h4C; // L
            4'd9:    ch = 8'h65; // e
            4'd10:   ch = 8'h6E; // n
            4'd11:   ch = 8'h67; // g
            4'd12:   ch = 8'h74; // t
            4'd13:   ch = 8'h68; // h
            4'd14:   ch = 8'h3A; // :
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_LF) ||
               (c == CHAR_VT) || (c == CHAR_FF) || (c == CHAR_CR);
    endfunction

    // Low field bits of a length-wide value, zero-extended when narrower
    function automatic logic [FIELD_WIDTH-1:0] to_field(input logic [LENGTH_WIDTH-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[FIELD_WIDTH-1:0];
    endfunction

endpackage

`default_nettype wire

[src/hmed_core.sv]
`default_nettype none

module hmed_core
    import hmed_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       step_en,
    input  wire logic [7:0] data_byte,
    input  wire logic       first_byte,
    output result_t         res
);

    localparam logic [LENGTH_WIDTH-1:0] LEN_MAX = '1;

    logic [2:0]              end_prog_reg,  end_prog_next;
    logic [3:0]              name_idx_reg,  name_idx_next;
    num_phase_t              phase_reg,     phase_next;
    logic                    minus_reg,     minus_next;
    logic [LENGTH_WIDTH-1:0] decl_len_reg,  decl_len_next;
    logic                    header_reg,    header_next;
    logic [LENGTH_WIDTH-1:0] body_cnt_reg,  body_cnt_next;
    logic                    done_reg,      done_next;

    // state as seen by this byte (first byte starts from clear)
    logic [2:0]              end_prog_cur;
    logic [3:0]              name_idx_cur;
    num_phase_t              phase_cur;
    logic                    minus_cur;
    logic [LENGTH_WIDTH-1:0] decl_len_cur;
    logic                    header_cur;
    logic [LENGTH_WIDTH-1:0] body_cnt_cur;
    logic                    done_cur;

    logic                    is_digit;
    logic [3:0]              digit_val;
    logic [3:0]              idx_eff;
    logic [4:0]              idx_inc;
    logic [LENGTH_WIDTH+3:0] decl_wide;
    logic [LENGTH_WIDTH+3:0] decl_sum;
    logic                    found;

    assign end_prog_cur = first_byte ? 3'd0 : end_prog_reg;
    assign name_idx_cur = first_byte ? 4'd0 : name_idx_reg;
    assign phase_cur    = first_byte ? NP_NO_NAME : phase_reg;
    assign minus_cur    = first_byte ? 1'b0 : minus_reg;
    assign decl_len_cur = first_byte ? '0 : decl_len_reg;
    assign header_cur   = first_byte ? 1'b0 : header_reg;
    assign body_cnt_cur = first_byte ? '0 : body_cnt_reg;
    assign done_cur     = first_byte ? 1'b0 : done_reg;

    assign is_digit  = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
    assign digit_val = 4'(data_byte - CHAR_ZERO);

    // decl * 10 + digit in a widened word, saturated below
    assign decl_wide = {4'd0, decl_len_cur};
    assign decl_sum  = (decl_wide << 3) + (decl_wide << 1) + (LENGTH_WIDTH+4)'(digit_val);

    assign idx_eff = (name_idx_cur >= 4'(NAME_LEN)) ? 4'd0 : name_idx_cur;
    assign idx_inc = 5'(idx_eff) + 5'd1;

    // header, name, number and body tracking
    always_comb begin
        end_prog_next = end_prog_cur;
        name_idx_next = name_idx_cur;
        phase_next    = phase_cur;
        minus_next    = minus_cur;
        decl_len_next = decl_len_cur;
        header_next   = header_cur;
        body_cnt_next = body_cnt_cur;

        if (header_cur) begin
            if (body_cnt_cur != LEN_MAX) begin
                body_cnt_next = body_cnt_cur + 1'b1;
            end
        end else begin
            case (phase_cur)
                NP_NO_NAME: begin
                    if (data_byte == name_char(idx_eff)) begin
                        if (idx_inc >= 5'(NAME_LEN)) begin
                            name_idx_next = 4'd0;
                            phase_next    = NP_LEAD;
                        end else begin
                            name_idx_next = idx_inc[3:0];
                        end
                    end else begin
                        name_idx_next = (data_byte == name_char(4'd0)) ? 4'd1 : 4'd0;
                    end
                end
                NP_LEAD: begin
                    if (is_blank(data_byte)) begin
                        phase_next = NP_LEAD;
                    end else if ((data_byte == CHAR_PLUS) || (data_byte == CHAR_MINUS)) begin
                        minus_next = (data_byte == CHAR_MINUS);
                        phase_next = NP_DIGITS;
                    end else if (is_digit) begin
                        phase_next    = NP_DIGITS;
                        decl_len_next = (decl_sum > (LENGTH_WIDTH+4)'(LEN_MAX)) ?
                                        LEN_MAX : decl_sum[LENGTH_WIDTH-1:0];
                    end else begin
                        phase_next = NP_ENDED;
                    end
                end
                NP_DIGITS: begin
                    if (is_digit) begin
                        decl_len_next = (decl_sum > (LENGTH_WIDTH+4)'(LEN_MAX)) ?
                                        LEN_MAX : decl_sum[LENGTH_WIDTH-1:0];
                    end else begin
                        phase_next = NP_ENDED;
                    end
                end
                default: begin
                    phase_next = phase_cur;
                end
            endcase

            // blank line search
            if (data_byte == CHAR_CR) begin
                end_prog_next = (end_prog_cur == 3'd2) ? 3'd3 : 3'd1;
            end else if ((data_byte == CHAR_LF) &&
                         ((end_prog_cur == 3'd1) || (end_prog_cur == 3'd3))) begin
                end_prog_next = end_prog_cur + 3'd1;
            end else begin
                end_prog_next = 3'd0;
            end
            if (end_prog_next >= 3'd4) begin
                header_next = 1'b1;
            end
        end
    end

    // completion
    assign found = (phase_next != NP_NO_NAME);
    always_comb begin
        done_next = done_cur;
        if (header_next && (!found || minus_next || (body_cnt_next >= decl_len_next))) begin
            done_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            end_prog_reg <= 3'd0;
            name_idx_reg <= 4'd0;
            phase_reg    <= NP_NO_NAME;
            minus_reg    <= 1'b0;
            decl_len_reg <= '0;
            header_reg   <= 1'b0;
            body_cnt_reg <= '0;
            done_reg     <= 1'b0;
        end else if (step_en) begin
            end_prog_reg <= end_prog_next;
            name_idx_reg <= name_idx_next;
            phase_reg    <= phase_next;
            minus_reg    <= minus_next;
            decl_len_reg <= decl_len_next;
            header_reg   <= header_next;
            body_cnt_reg <= body_cnt_next;
            done_reg     <= done_next;
        end
    end

    // result for this byte
    always_comb begin
        res.message_complete = done_next;
        res.header_complete  = header_next;
        res.length_found     = found;
        res.expected_length  = to_field(decl_len_next);
        res.body_bytes       = to_field(body_cnt_next);
    end

endmodule

`default_nettype wire

[src/http_message_end_detector_top.sv]
`default_nettype none

// Channel   Ports                     Contents
// input     s_tvalid/s_tready         s_tdata[7:0] data_byte; s_tuser[0] first_byte
// result    m_tvalid/m_tready         m_tdata: complete, header, found, length, count
//
// One result beat per input beat, one beat per cycle sustained while m_tready is high.
// A byte is held in the input register, is processed on its way into the
// result register and shows on m_tdata from there.
// Synchronous active-low reset clears the tracking state and both valid flags.
// A stall on m_tready holds the result; the input register holds at most one more byte, then s_tready drops.

module http_message_end_detector_top
    import hmed_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic [0:0]  s_tuser,   // [0] first_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata    // [0] message_complete, [1] header_complete,
                                        // [2] length_found, [34:3] expected_length,
                                        // [66:35] body_bytes, [71:67] zero
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_first_reg;
    logic       out_valid_reg;
    result_t    out_res_reg;
    result_t    core_res;
    logic       advance;

    // move a byte from the input register into the result register
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    hmed_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (advance),
        .data_byte  (in_byte_reg),
        .first_byte (in_first_reg),
        .res        (core_res)
    );

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg  <= s_tdata;
            in_first_reg <= s_tuser[0];
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= core_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_res_reg};

endmodule

`default_nettype wire
